// ===== rtl/pfp_pkg.sv =====
// Shared types, widths and helpers for the point frustum projection block.
`default_nettype none
package pfp_pkg;

  localparam int QW = 44;
  localparam int DW = 18;
  localparam int CW = 29;

  typedef enum logic [3:0] {
    REG_ROT_X  = 4'd0,
    REG_ROT_Y  = 4'd1,
    REG_ROT_Z  = 4'd2,
    REG_SHF_X  = 4'd3,
    REG_SHF_Y  = 4'd4,
    REG_SHF_Z  = 4'd5,
    REG_LENS   = 4'd6,
    REG_FRAME  = 4'd7
  } pfp_reg_e;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] num;
  } pfp_lane_t;

  typedef struct packed {
    logic          valid;
    logic          ok;
    logic          neg_u;
    logic          neg_v;
    logic [CW-1:0] cz;
    logic [DW-1:0] div;
    pfp_lane_t     lu;
    pfp_lane_t     lv;
  } pfp_item_t;

  function automatic pfp_lane_t pfp_step(input pfp_lane_t ln, input logic [DW-1:0] dv);
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    pfp_lane_t   r;
    t    = {ln.rem, ln.num[QW-1]};
    diff = t - {1'b0, dv};
    ge   = (t >= {1'b0, dv});
    r.rem = ge ? diff[DW-1:0] : t[DW-1:0];
    r.num = {ln.num[QW-2:0], ge};
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pfp_xform.sv =====
// Pose transform, depth test and focal multiply ahead of the divider chain.
`default_nettype none
module pfp_xform
  import pfp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               load_i,
  input  wire logic signed [23:0] point_x_i,
  input  wire logic signed [23:0] point_y_i,
  input  wire logic signed [23:0] point_z_i,
  input  wire logic [47:0]        rot_x_i,
  input  wire logic [47:0]        rot_y_i,
  input  wire logic [47:0]        rot_z_i,
  input  wire logic signed [23:0] shf_x_i,
  input  wire logic signed [23:0] shf_y_i,
  input  wire logic signed [23:0] shf_z_i,
  input  wire logic [63:0]        lens_i,
  input  wire logic [63:0]        frame_i,
  output pfp_item_t               item_o
);

  logic signed [39:0] m_q [3][3];
  logic               v1_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic               v2_q;
  logic signed [45:0] pu_q, pv_q;
  logic [CW-1:0]      cz3_q;
  logic               ok_q;
  logic               v3_q;

  logic [47:0]        rows [3];
  logic signed [23:0] pts [3];
  logic signed [41:0] s [3];
  logic signed [CW-1:0] c_d [3];
  logic signed [23:0] shf [3];
  logic [DW-1:0]      near4, far4;
  logic               ok_d;
  logic [45:0]        mag_u, mag_v;

  assign rows[0] = rot_x_i;
  assign rows[1] = rot_y_i;
  assign rows[2] = rot_z_i;
  assign pts[0]  = point_x_i;
  assign pts[1]  = point_y_i;
  assign pts[2]  = point_z_i;
  assign shf[0]  = shf_x_i;
  assign shf[1]  = shf_y_i;
  assign shf[2]  = shf_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= load_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          m_q[i][k] <= $signed(rows[i][16*k +: 16]) * pts[k];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s[i]   = 42'(m_q[i][0]) + 42'(m_q[i][1]) + 42'(m_q[i][2]);
      c_d[i] = CW'(s[i] >>> 14) + CW'(shf[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q <= c_d[0];
      cy_q <= c_d[1];
      cz_q <= c_d[2];
    end
  end

  assign near4 = {frame_i[47:32], 2'b00};
  assign far4  = {frame_i[63:48], 2'b00};
  assign ok_d  = (cz_q > 0) && (cz_q >= $signed({11'd0, near4}))
                 && (cz_q <= $signed({11'd0, far4}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pu_q  <= $signed({1'b0, lens_i[15:0]}) * cx_q;
      pv_q  <= $signed({1'b0, lens_i[31:16]}) * cy_q;
      cz3_q <= cz_q;
      ok_q  <= ok_d;
    end
  end

  assign mag_u = pu_q[45] ? 46'(-pu_q) : pu_q;
  assign mag_v = pv_q[45] ? 46'(-pv_q) : pv_q;

  always_comb begin
    item_o.valid  = v3_q;
    item_o.ok     = ok_q;
    item_o.neg_u  = pu_q[45];
    item_o.neg_v  = pv_q[45];
    item_o.cz     = cz3_q;
    item_o.div    = cz3_q[DW-1:0];
    item_o.lu.rem = '0;
    item_o.lu.num = mag_u[QW-1:0];
    item_o.lv.rem = '0;
    item_o.lv.num = mag_v[QW-1:0];
  end

endmodule
`default_nettype wire

// ===== rtl/pfp_div_cell.sv =====
// One restoring division step for both pixel lanes, registered.
`default_nettype none
module pfp_div_cell
  import pfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  pfp_item_t item_i,
  output pfp_item_t item_o
);

  pfp_item_t item_d, item_q;

  always_comb begin
    item_d    = item_i;
    item_d.lu = pfp_step(item_i.lu, item_i.div);
    item_d.lv = pfp_step(item_i.lv, item_i.div);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule
`default_nettype wire

// ===== rtl/point_frustum_projection.sv =====
// Top level: config registers, transform front end, divider chain, output register.
//
//  channel | signals                                   | direction
//  in      | in_valid_i, in_stall_o, point_x/y/z_i     | upstream -> block
//  out     | out_valid_o, out_stall_i, inside_res_o,   | block -> downstream
//          | pixel_u_o, pixel_v_o, cam_depth_o         |
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,    | host -> block
//          | cfg_data_i                                |
//
// One point per cycle unless the output stalls. The points pass three transform
// stages, 44 divider cells (one quotient bit each) and the output register.
// Reset sets the pose to identity and the frame to 640x480, near 0, far 65535.
// A stalled output freezes the whole pipeline and raises in_stall_o.
`default_nettype none
module point_frustum_projection
  import pfp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output wire logic               in_stall_o,
  input  wire logic signed [23:0] point_x_i,
  input  wire logic signed [23:0] point_y_i,
  input  wire logic signed [23:0] point_z_i,
  output wire logic               out_valid_o,
  input  wire logic               out_stall_i,
  output wire logic               inside_res_o,
  output wire logic signed [23:0] pixel_u_o,
  output wire logic signed [23:0] pixel_v_o,
  output wire logic signed [23:0] cam_depth_o,
  input  wire logic               cfg_valid_i,
  output wire logic               cfg_ready_o,
  input  wire logic [3:0]         cfg_index_i,
  input  wire logic [63:0]        cfg_data_i
);

  logic [47:0]        rot_x_q, rot_y_q, rot_z_q;
  logic signed [23:0] shf_x_q, shf_y_q, shf_z_q;
  logic [63:0]        lens_q, frame_q;

  logic               en;
  logic               out_valid_q, inside_q;
  logic signed [23:0] u_q, v_q, d_q;
  pfp_item_t          chain [QW+1];
  pfp_item_t          last;

  logic signed [45:0] qu, qv, uu, vv;
  logic               in_img;
  logic signed [23:0] u_d, v_d, d_d;
  logic               inside_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_x_q <= 48'd16384;
      rot_y_q <= 48'd16384 << 16;
      rot_z_q <= 48'd16384 << 32;
      shf_x_q <= '0;
      shf_y_q <= '0;
      shf_z_q <= '0;
      lens_q  <= '0;
      frame_q <= 64'hFFFF_0000_01E0_0280;
    end else if (cfg_valid_i) begin
      case (pfp_reg_e'(cfg_index_i))
        REG_ROT_X: rot_x_q <= cfg_data_i[47:0];
        REG_ROT_Y: rot_y_q <= cfg_data_i[47:0];
        REG_ROT_Z: rot_z_q <= cfg_data_i[47:0];
        REG_SHF_X: shf_x_q <= cfg_data_i[23:0];
        REG_SHF_Y: shf_y_q <= cfg_data_i[23:0];
        REG_SHF_Z: shf_z_q <= cfg_data_i[23:0];
        REG_LENS:  lens_q  <= cfg_data_i;
        REG_FRAME: frame_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  pfp_xform u_xform (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .load_i    (in_valid_i),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .rot_x_i   (rot_x_q),
    .rot_y_i   (rot_y_q),
    .rot_z_i   (rot_z_q),
    .shf_x_i   (shf_x_q),
    .shf_y_i   (shf_y_q),
    .shf_z_i   (shf_z_q),
    .lens_i    (lens_q),
    .frame_i   (frame_q),
    .item_o    (chain[0])
  );

  for (genvar g = 0; g < QW; g++) begin : g_cell
    pfp_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  assign last = chain[QW];

  always_comb begin
    qu = $signed({2'b00, last.lu.num});
    qv = $signed({2'b00, last.lv.num});
    uu = (last.neg_u ? -qu : qu) + $signed({30'd0, lens_q[47:32]});
    vv = (last.neg_v ? -qv : qv) + $signed({30'd0, lens_q[63:48]});
    in_img = !uu[45] && (uu < $signed({26'd0, frame_q[15:0], 4'd0}))
             && !vv[45] && (vv < $signed({26'd0, frame_q[31:16], 4'd0}));
    if (uu > 46'sd8388607) begin
      u_d = 24'sh7FFFFF;
    end else if (uu < -46'sd8388608) begin
      u_d = 24'sh800000;
    end else begin
      u_d = uu[23:0];
    end
    if (vv > 46'sd8388607) begin
      v_d = 24'sh7FFFFF;
    end else if (vv < -46'sd8388608) begin
      v_d = 24'sh800000;
    end else begin
      v_d = vv[23:0];
    end
    d_d      = last.cz[23:0];
    inside_d = in_img;
    if (!last.ok) begin
      u_d      = -24'sd16;
      v_d      = -24'sd16;
      d_d      = -24'sd1024;
      inside_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_q <= inside_d;
      u_q      <= u_d;
      v_q      <= v_d;
      d_q      <= d_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;
  assign pixel_u_o    = u_q;
  assign pixel_v_o    = v_q;
  assign cam_depth_o  = d_q;

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_out_of_range_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cam_depth_o[23]) |-> (pixel_u_o == -24'sd16 && !inside_res_o))
    else $error("out-of-range result not marked");

  a_inside_nonneg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inside_res_o) |-> (!pixel_u_o[23] && !pixel_v_o[23]))
    else $error("inside result with negative pixel");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the point frustum projection block.
`timescale 1ns / 100ps
module testbench;
  import pfp_pkg::*;

  typedef struct {
    logic signed [23:0] x, y, z;
  } point_t;

  typedef struct {
    logic               in_view;
    logic signed [23:0] u, v, depth;
  } proj_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  wire                in_stall_o;
  logic signed [23:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  wire                out_valid_o;
  logic               out_stall_i = 1'b0;
  wire                inside_res_o;
  wire signed [23:0]  pixel_u_o, pixel_v_o, cam_depth_o;
  logic               cfg_valid_i = 1'b0;
  wire                cfg_ready_o;
  logic [3:0]         cfg_index_i = '0;
  logic [63:0]        cfg_data_i = '0;

  point_frustum_projection u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [63:0] pose_regs [8];
  point_t      pending_points [$];
  proj_t       expected_projs [$];
  int          send_idle_pct = 0, stall_pct = 0, hold_cycles = 0;
  int          errors = 0, checked = 0, inside_count = 0, cycles = 0;

  function automatic logic signed [63:0] camera_axis(input logic [47:0] row,
                                                      input logic signed [23:0] shf,
                                                      input point_t p);
    logic signed [63:0] s;
    s = $signed(row[15:0]) * 64'(p.x) + $signed(row[31:16]) * 64'(p.y)
      + $signed(row[47:32]) * 64'(p.z);
    return (s >>> 14) + 64'(shf);
  endfunction

  function automatic logic signed [63:0] sat24(input logic signed [63:0] a);
    if (a > 64'sd8388607) return 64'sd8388607;
    if (a < -64'sd8388608) return -64'sd8388608;
    return a;
  endfunction

  function automatic proj_t project_point(input point_t p);
    logic signed [63:0] cx, cy, cz, u, v, fx, fy;
    proj_t r;
    cx = camera_axis(pose_regs[REG_ROT_X][47:0], pose_regs[REG_SHF_X][23:0], p);
    cy = camera_axis(pose_regs[REG_ROT_Y][47:0], pose_regs[REG_SHF_Y][23:0], p);
    cz = camera_axis(pose_regs[REG_ROT_Z][47:0], pose_regs[REG_SHF_Z][23:0], p);
    if (cz <= 0 || cz < 4 * $signed({48'd0, pose_regs[REG_FRAME][47:32]})
        || cz > 4 * $signed({48'd0, pose_regs[REG_FRAME][63:48]})) begin
      r.in_view = 1'b0;
      r.u = -24'sd16;
      r.v = -24'sd16;
      r.depth = -24'sd1024;
      return r;
    end
    fx = $signed({48'd0, pose_regs[REG_LENS][15:0]});
    fy = $signed({48'd0, pose_regs[REG_LENS][31:16]});
    u = (fx * cx) / cz + $signed({48'd0, pose_regs[REG_LENS][47:32]});
    v = (fy * cy) / cz + $signed({48'd0, pose_regs[REG_LENS][63:48]});
    r.in_view = u >= 0 && u < 16 * $signed({48'd0, pose_regs[REG_FRAME][15:0]})
             && v >= 0 && v < 16 * $signed({48'd0, pose_regs[REG_FRAME][31:16]});
    r.u = sat24(u);
    r.v = sat24(v);
    r.depth = sat24(cz);
    return r;
  endfunction

  always @(posedge clk_i) begin
    point_t p;
    if (in_valid_i && !in_stall_o) begin
      void'(pending_points.pop_front());
      expected_projs.insert(expected_projs.size(),
                            project_point('{point_x_i, point_y_i, point_z_i}));
    end
    if (pending_points.size() > (in_valid_i && !in_stall_o ? 0 : 0) &&
        !(in_valid_i && in_stall_o)) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        p = pending_points[0];
        in_valid_i <= 1'b1;
        point_x_i <= p.x;
        point_y_i <= p.y;
        point_z_i <= p.z;
      end else begin
        in_valid_i <= 1'b0;
      end
    end else if (!(in_valid_i && in_stall_o)) begin
      in_valid_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    proj_t e;
    cycles <= cycles + 1;
    if (out_valid_o && !out_stall_i) begin
      if (expected_projs.size() == 0) begin
        $error("unexpected transfer u=%0d v=%0d", pixel_u_o, pixel_v_o);
        errors = errors + 1;
      end else begin
        e = expected_projs.pop_front();
        checked <= checked + 1;
        inside_count <= inside_count + e.in_view;
        if (inside_res_o !== e.in_view) begin
          $error("inside_res exp %0d got %0d", e.in_view, inside_res_o);
          errors = errors + 1;
        end
        if (pixel_u_o !== e.u) begin
          $error("pixel_u exp %0d got %0d", e.u, pixel_u_o);
          errors = errors + 1;
        end
        if (pixel_v_o !== e.v) begin
          $error("pixel_v exp %0d got %0d", e.v, pixel_v_o);
          errors = errors + 1;
        end
        if (cam_depth_o !== e.depth) begin
          $error("cam_depth exp %0d got %0d", e.depth, cam_depth_o);
          errors = errors + 1;
        end
      end
    end
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input pfp_reg_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx <= REG_ROT_Z) pose_regs[idx] = val & 64'hFFFF_FFFF_FFFF;
    else if (idx <= REG_SHF_Z) pose_regs[idx] = val & 64'hFF_FFFF;
    else pose_regs[idx] = val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || in_valid_i || expected_projs.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic signed [23:0] rnd_coord();
    case ($urandom_range(3))
      0: return $signed(24'($urandom));
      1: return $signed(24'($urandom_range(16384))) - 24'sd8192;
      default: return $signed(24'($urandom_range(40000))) - 24'sd20000;
    endcase
  endfunction

  function automatic logic [15:0] rnd_q14();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      default: return 16'($signed(16'($urandom_range(32768))) - 16'sd16384);
    endcase
  endfunction

  task automatic random_setting(input int k);
    write_reg(REG_ROT_X, {rnd_q14(), rnd_q14(), rnd_q14()});
    write_reg(REG_ROT_Y, {rnd_q14(), rnd_q14(), rnd_q14()});
    write_reg(REG_ROT_Z, {rnd_q14(), rnd_q14(), rnd_q14()});
    write_reg(REG_SHF_X, k[0] ? 64'($urandom) : 64'($urandom_range(4000)));
    write_reg(REG_SHF_Y, k[1] ? 64'($urandom) : 64'($urandom_range(4000)));
    write_reg(REG_SHF_Z, k[0] ? 64'($urandom) : 64'($urandom_range(20000)));
    write_reg(REG_LENS, k[2] ? {$urandom, $urandom}
             : {16'($urandom_range(8000)), 16'($urandom_range(8000)),
                16'($urandom_range(9000)), 16'($urandom_range(9000))});
    write_reg(REG_FRAME, k[1] ? {$urandom, $urandom}
              : {16'($urandom_range(40, 65535)), 16'($urandom_range(8)),
                 16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000))});
  endtask

  initial begin
    point_t p;
    pose_regs[0] = 64'd16384;
    pose_regs[1] = 64'd16384 << 16;
    pose_regs[2] = 64'd16384 << 32;
    pose_regs[3] = 0;
    pose_regs[4] = 0;
    pose_regs[5] = 0;
    pose_regs[6] = 0;
    pose_regs[7] = 64'hFFFF_0000_01E0_0280;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset pose, extremes, depth cases
    pending_points.insert(pending_points.size(), '{24'sd0, 24'sd0, 24'sd0});
    pending_points.insert(pending_points.size(),
                          '{24'sd8388607, 24'sd8388607, 24'sd8388607});
    pending_points.insert(pending_points.size(),
                          '{-24'sd8388608, -24'sd8388608, -24'sd8388608});
    pending_points.insert(pending_points.size(), '{24'sd100, -24'sd100, 24'sd1});
    drain();
    write_reg(REG_LENS, {16'd3840, 16'd5120, 16'd8000, 16'd8000});
    write_reg(REG_FRAME, {16'd65535, 16'd0, 16'd480, 16'd640});
    pending_points.insert(pending_points.size(), '{24'sd0, 24'sd0, 24'sd1024});
    pending_points.insert(pending_points.size(), '{24'sd1000, -24'sd800, 24'sd2048});
    pending_points.insert(pending_points.size(),
                          '{-24'sd8388608, 24'sd8388607, 24'sd1});
    pending_points.insert(pending_points.size(),
                          '{24'sd8388607, -24'sd8388608, 24'sd8388607});
    pending_points.insert(pending_points.size(), '{24'sd5, 24'sd5, -24'sd5});
    pending_points.insert(pending_points.size(), '{24'sd50, 24'sd50, 24'sd0});
    drain();
    write_reg(REG_FRAME, {16'd100, 16'd4000, 16'd0, 16'd640});
    pending_points.insert(pending_points.size(), '{24'sd0, 24'sd0, 24'sd1024});
    pending_points.insert(pending_points.size(), '{24'sd0, 24'sd0, 24'sd16000});
    drain();
    write_reg(REG_FRAME, {16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF});
    write_reg(REG_SHF_Z, 64'h80_0000);
    write_reg(REG_SHF_X, 64'h7F_FFFF);
    write_reg(REG_SHF_Y, 64'h80_0000);
    pending_points.insert(pending_points.size(), '{24'sd0, 24'sd0, 24'sd0});
    pending_points.insert(pending_points.size(), '{24'sd8388607, 24'sd0, 24'sd8388607});
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      random_setting(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 46; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 46; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      if (ph == 5) hold_cycles = 200;
      repeat (75) begin
        p.x = rnd_coord();
        p.y = rnd_coord();
        p.z = rnd_coord();
        pending_points.insert(pending_points.size(), p);
      end
      drain();
    end
    stall_pct = 0;
    $display("checked %0d projections over 14 random poses, %0d inside the image",
             checked, inside_count);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/pfp_pkg.sv
rtl/pfp_xform.sv
rtl/pfp_div_cell.sv
rtl/point_frustum_projection.sv
test/testbench.sv
